FILE: hdl/vsrc4_pkg.sv
package vsrc4_pkg;

	// Sizes of the stores and of the fields
	localparam int PERM_MAX = 256;
	localparam int KEY_MAX  = 32;
	localparam int PERM_AW  = $clog2(PERM_MAX);
	localparam int KEY_AW   = $clog2(KEY_MAX);
	localparam int N_W      = 9;
	localparam int KLEN_W   = 6;
	localparam int DIVD_W   = 10;
	localparam int MOD_STEPS = DIVD_W;

	localparam logic [N_W-1:0]    PERM_MAX_N  = N_W'(PERM_MAX);
	localparam logic [KLEN_W-1:0] KEY_MAX_LEN = KLEN_W'(KEY_MAX);

	// Item kinds
	typedef enum logic [1:0] {
		FUNC_KEY   = 2'd0,
		FUNC_SCHED = 2'd1,
		FUNC_DATA  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// Register indexes on the configuration port
	localparam logic CFG_PERM_SIZE  = 1'b0;
	localparam logic CFG_KEY_LENGTH = 1'b1;

	typedef struct packed {
		func_t       func;
		logic [4:0]  key_index;
		logic [7:0]  data_in;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  data_out;
		logic        status;
	} result_t;

endpackage

FILE: hdl/variable_size_rc4_cipher.sv
// Variable-size RC4-style stream cipher.
// Input beats arrive on s_tvalid/s_tready with the item kind on s_tuser: load a
// key byte, run the key schedule, or cipher one data byte. Each input beat
// gives exactly one output beat on m_tvalid/m_tready: the ciphered byte on
// m_tdata and a status flag on m_tuser (set for a data byte before any schedule).
// The user writes perm_size and key_length through cfg_we/cfg_index/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// One item is worked at a time; s_tready is high only while the sequencer idles.
// A key load or a refused data byte passes through the response state and then
// the output register. A data byte needs no long division when every index sum
// stays below twice N; for each of its three reductions whose sum does not, the
// shared modulo unit walks all 10 dividend bits. The key schedule first fills
// the permutation, then works each of N entries in turn, paced by the modulo
// unit and the single write port of the permutation memory.
// Reset clears the stream indices, the key position and the schedule flag, and
// restores perm_size to 256 and key_length to 1; key bytes and the permutation
// hold garbage until loaded and scheduled.
// A stalled receiver holds the result in the output register; the next item is
// still taken and worked, and its result waits in the sequencer until the
// output register frees.
module variable_size_rc4_cipher
	import vsrc4_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // [4:0] key_index, [12:5] data_in, rest zero
	input  logic [1:0]        s_tuser,   // [1:0] func
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [7:0] data_out
	output logic              m_tuser,   // [0] status
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [N_W-1:0]    cfg_wdata
);

	logic [N_W-1:0]    perm_size_q;
	logic [KLEN_W-1:0] key_length_q;
	logic [N_W-1:0]    perm_n;
	logic [KLEN_W-1:0] key_len;

	logic    core_idle;
	logic    start;
	item_t   item;
	result_t res;
	logic    res_ack;

	logic       m_tvalid_q;
	logic [7:0] m_data_q;
	logic       m_status_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_size_q  <= PERM_MAX_N;
			key_length_q <= KLEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PERM_SIZE:  perm_size_q  <= cfg_wdata;
				CFG_KEY_LENGTH: key_length_q <= cfg_wdata[KLEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the registers into their working ranges
	always_comb begin
		priority if (perm_size_q == '0) begin
			perm_n = N_W'(1);
		end else if (perm_size_q > PERM_MAX_N) begin
			perm_n = PERM_MAX_N;
		end else begin
			perm_n = perm_size_q;
		end
		priority if (key_length_q == '0) begin
			key_len = KLEN_W'(1);
		end else if (key_length_q > KEY_MAX_LEN) begin
			key_len = KEY_MAX_LEN;
		end else begin
			key_len = key_length_q;
		end
	end

	// Unpack the input beat
	assign s_tready       = core_idle;
	assign start          = s_tvalid && core_idle;
	assign item.func      = func_t'(s_tuser);
	assign item.key_index = s_tdata[4:0];
	assign item.data_in   = s_tdata[12:5];

	vsrc4_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item    (item),
		.perm_n  (perm_n),
		.key_len (key_len),
		.idle    (core_idle),
		.res     (res),
		.res_ack (res_ack)
	);

	// Output register: load when empty or being drained
	assign res_ack = res.valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ack) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			m_data_q   <= res.data_out;
			m_status_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_status_q;

endmodule

FILE: hdl/vsrc4_mod.sv
module vsrc4_mod
	import vsrc4_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [N_W-1:0]    divisor,
	output logic              done,
	output logic [7:0]        remainder
);

	logic              busy_q;
	logic              done_q;
	logic [3:0]        cnt_q;
	logic [DIVD_W-1:0] num_q;
	logic [N_W-1:0]    div_q;
	logic [N_W-1:0]    rem_q;

	logic [DIVD_W:0]   diff1;
	logic [DIVD_W-1:0] trial;
	logic [DIVD_W-1:0] trial_sub;

	// One subtract covers sums below twice the modulus
	assign diff1     = {1'b0, dividend} - {2'b0, divisor};
	assign trial     = {rem_q, num_q[DIVD_W-1]};
	assign trial_sub = trial - {1'b0, div_q};

	// Restoring reduction, one dividend bit per cycle on the slow path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (dividend < {1'b0, divisor}) begin
					done_q <= 1'b1;
				end else if (diff1[DIVD_W-1:0] < {1'b0, divisor}) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 4'(MOD_STEPS - 1);
				end
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
		end
	end

	// Datapath of the reduction
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			num_q <= dividend;
			if (dividend < {1'b0, divisor}) begin
				rem_q <= dividend[N_W-1:0];
			end else if (diff1[DIVD_W-1:0] < {1'b0, divisor}) begin
				rem_q <= diff1[N_W-1:0];
			end else begin
				rem_q <= '0;
			end
		end else if (busy_q) begin
			num_q <= {num_q[DIVD_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= trial_sub[N_W-1:0];
			end else begin
				rem_q <= trial[N_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[7:0];

endmodule

FILE: hdl/vsrc4_core.sv
module vsrc4_core
	import vsrc4_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  item_t             item,
	input  logic [N_W-1:0]    perm_n,
	input  logic [KLEN_W-1:0] key_len,
	output logic              idle,
	output result_t           res,
	input  logic              res_ack
);

	typedef enum logic [14:0] {
		ST_IDLE = 15'b000000000000001,
		ST_FILL = 15'b000000000000010,
		ST_KRD  = 15'b000000000000100,
		ST_KSUM = 15'b000000000001000,
		ST_KMOD = 15'b000000000010000,
		ST_KSW1 = 15'b000000000100000,
		ST_KSW2 = 15'b000000001000000,
		ST_CIW  = 15'b000000010000000,
		ST_CSI  = 15'b000000100000000,
		ST_CJW  = 15'b000001000000000,
		ST_CSJ  = 15'b000010000000000,
		ST_CWJ  = 15'b000100000000000,
		ST_CKW  = 15'b001000000000000,
		ST_COUT = 15'b010000000000000,
		ST_RESP = 15'b100000000000000
	} state_t;

	state_t state_q;

	// Permutation memory, one write and one registered read a cycle
	logic [7:0] perm_mem [PERM_MAX];
	logic [7:0] rdata_q;
	logic               we;
	logic [PERM_AW-1:0] waddr;
	logic [7:0]         wdata;
	logic [PERM_AW-1:0] raddr;

	// Key bytes
	logic [7:0]        key_q [KEY_MAX];
	logic [KEY_AW-1:0] key_raddr;
	logic [7:0]        key_rd;

	// Stream and schedule registers
	logic [7:0]        i_q;
	logic [7:0]        j_q;
	logic [KEY_AW-1:0] kpos_q;
	logic              sched_q;
	logic [N_W-1:0]    m_q;
	logic [KLEN_W-1:0] kc_q;
	logic [7:0]        sm_q;
	logic [7:0]        si_q;
	logic [7:0]        data_q;
	logic [7:0]        kb_q;
	logic [7:0]        out_data_q;
	logic              out_status_q;

	// Shared modulo unit
	logic              mod_start;
	logic [DIVD_W-1:0] mod_divd;
	logic              mod_done;
	logic [7:0]        mod_rem;

	logic [N_W-1:0]    fill_val;
	logic [KLEN_W-1:0] key_back;
	logic [KLEN_W-1:0] kpos_inc;
	logic [KLEN_W-1:0] kc_inc;
	logic              m_last;

	vsrc4_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mod_divd),
		.divisor   (perm_n),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	assign fill_val = perm_n - N_W'(1) - m_q;
	assign key_back = key_len - KLEN_W'(1) - kc_q;
	assign kpos_inc = {1'b0, kpos_q} + KLEN_W'(1);
	assign kc_inc   = kc_q + KLEN_W'(1);
	assign m_last   = (m_q == perm_n - N_W'(1));
	assign key_rd   = key_q[key_raddr];

	// Steer memory ports, key read and the modulo unit by state
	always_comb begin
		we        = 1'b0;
		waddr     = '0;
		wdata     = '0;
		raddr     = '0;
		key_raddr = kpos_q;
		mod_start = 1'b0;
		mod_divd  = '0;
		unique case (state_q)
			ST_IDLE: begin
				mod_start = start && (item.func == FUNC_DATA) && sched_q;
				mod_divd  = {2'b0, i_q} + DIVD_W'(1);
			end
			ST_FILL: begin
				we    = 1'b1;
				waddr = m_q[PERM_AW-1:0];
				wdata = fill_val[7:0];
			end
			ST_KRD: begin
				raddr = m_q[PERM_AW-1:0];
			end
			ST_KSUM: begin
				key_raddr = key_back[KEY_AW-1:0];
				mod_start = 1'b1;
				mod_divd  = {2'b0, j_q} + {2'b0, rdata_q} + {2'b0, key_rd};
			end
			ST_KMOD: begin
				raddr = mod_rem;
			end
			ST_KSW1: begin
				we    = 1'b1;
				waddr = m_q[PERM_AW-1:0];
				wdata = rdata_q;
			end
			ST_KSW2: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = sm_q;
			end
			ST_CIW: begin
				raddr = mod_rem;
			end
			ST_CSI: begin
				mod_start = 1'b1;
				mod_divd  = {2'b0, j_q} + {2'b0, rdata_q};
			end
			ST_CJW: begin
				raddr = mod_rem;
			end
			ST_CSJ: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = rdata_q;
			end
			ST_CWJ: begin
				we        = 1'b1;
				waddr     = j_q;
				wdata     = si_q;
				mod_start = 1'b1;
				mod_divd  = {2'b0, si_q} + {2'b0, sm_q};
			end
			ST_CKW: begin
				raddr = mod_rem;
			end
			ST_COUT: begin
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Memory and key store
	always_ff @(posedge clk) begin
		if (we) begin
			perm_mem[waddr] <= wdata;
		end
		rdata_q <= perm_mem[raddr];
		if (state_q == ST_IDLE && start && item.func == FUNC_KEY) begin
			key_q[item.key_index] <= item.data_in;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			kpos_q  <= '0;
			sched_q <= 1'b0;
			m_q     <= '0;
			kc_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (item.func)
							FUNC_SCHED: begin
								m_q     <= '0;
								state_q <= ST_FILL;
							end
							FUNC_DATA: begin
								if (sched_q) begin
									kpos_q  <= (kpos_inc >= key_len) ? '0 :
										kpos_inc[KEY_AW-1:0];
									state_q <= ST_CIW;
								end else begin
									state_q <= ST_RESP;
								end
							end
							FUNC_KEY, FUNC_NONE: begin
								state_q <= ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_FILL: begin
					if (m_last) begin
						m_q     <= '0;
						kc_q    <= '0;
						j_q     <= '0;
						state_q <= ST_KRD;
					end else begin
						m_q <= m_q + N_W'(1);
					end
				end
				ST_KRD: state_q <= ST_KSUM;
				ST_KSUM: state_q <= ST_KMOD;
				ST_KMOD: begin
					if (mod_done) begin
						j_q     <= mod_rem;
						state_q <= ST_KSW1;
					end
				end
				ST_KSW1: state_q <= ST_KSW2;
				ST_KSW2: begin
					if (m_last) begin
						i_q     <= '0;
						j_q     <= '0;
						kpos_q  <= '0;
						sched_q <= 1'b1;
						state_q <= ST_RESP;
					end else begin
						m_q     <= m_q + N_W'(1);
						kc_q    <= (kc_inc >= key_len) ? '0 : kc_inc;
						state_q <= ST_KRD;
					end
				end
				ST_CIW: begin
					if (mod_done) begin
						i_q     <= mod_rem;
						state_q <= ST_CSI;
					end
				end
				ST_CSI: state_q <= ST_CJW;
				ST_CJW: begin
					if (mod_done) begin
						j_q     <= mod_rem;
						state_q <= ST_CSJ;
					end
				end
				ST_CSJ: state_q <= ST_CWJ;
				ST_CWJ: state_q <= ST_CKW;
				ST_CKW: begin
					if (mod_done) begin
						state_q <= ST_COUT;
					end
				end
				ST_COUT: state_q <= ST_RESP;
				ST_RESP: begin
					if (res_ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload: captured operands and the result byte
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				data_q       <= item.data_in;
				kb_q         <= key_rd;
				out_data_q   <= '0;
				out_status_q <= (item.func == FUNC_DATA) && !sched_q;
			end
			ST_KSUM: sm_q <= rdata_q;
			ST_CSI:  si_q <= rdata_q;
			ST_CSJ:  sm_q <= rdata_q;
			ST_COUT: begin
				out_data_q   <= data_q ^ kb_q ^ rdata_q;
				out_status_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign idle         = (state_q == ST_IDLE);
	assign res.valid    = (state_q == ST_RESP);
	assign res.data_out = out_data_q;
	assign res.status   = out_status_q;

endmodule
